@@ design/ffha_pkg.sv @@
`timescale 1ns / 1ps
// ffha_pkg: shared types and constants for the first-fit heap allocator
// no dependencies

package ffha_pkg;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [0:0] REG_HEAP_BASE  = 1'b0;
    localparam logic [0:0] REG_HEAP_BYTES = 1'b1;

    localparam int unsigned SIZE_W = 17;

    // one block table entry: offset and size within the region, occupied mark
    typedef struct packed {
        logic [SIZE_W-1:0] off;
        logic [SIZE_W-1:0] size;
        logic              occ;
    } t_entry;

endpackage

@@ design/ffha_table.sv @@
`timescale 1ns / 1ps
// ffha_table: block table memory, one write port and one registered read port
// depends on ffha_pkg

module ffha_table #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_BLOCKS)-1:0] i_waddr,
    input  ffha_pkg::t_entry              i_wdata,
    input  logic [$clog2(MAX_BLOCKS)-1:0] i_raddr,
    output ffha_pkg::t_entry              o_rdata
);

    ffha_pkg::t_entry r_mem [MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/first_fit_heap_allocator_top.sv @@
`timescale 1ns / 1ps
// first_fit_heap_allocator_top: sequencer over the block table memory
// depends on ffha_pkg and ffha_table
//
// usage
//   an item is taken when i_start is high and o_busy low; i_mode selects
//   allocate (0) or free (1). the single result appears on o_payload_address
//   and o_success, marked by o_done for one cycle; it cannot be held off.
//   configuration writes use i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; they are accepted only while idle, and any write forces the
//   table to be rebuilt on the next item, as one free block if it fits.
// timing
//   every item walks the table one entry at a time through the single
//   read port (address, then registered data). a zero-size allocate
//   ends before any entry is tested; a failed search tests every entry.
//   an allocate taken whole marks its entry; one with a split first
//   shifts the entries above it up, then writes the tail and the head.
//   a free adds to its search a merge pass from entry 0 that compares
//   each adjacent pair and shifts entries down on a merge. o_done rises
//   in the same cycle that o_busy falls, and a new item may be taken in it.
// reset
//   synchronous active-low; the state, count and config registers reset and the
//   table is marked unbuilt. the table memory itself is not cleared.
//   the receiver cannot stall, so results never wait.

module first_fit_heap_allocator_top #(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [15:0] i_request_bytes,
    input  logic [31:0] i_release_address,
    output logic        o_done,
    output logic [31:0] o_payload_address,
    output logic        o_success,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = ffha_pkg::SIZE_W;
    localparam logic [SW-1:0] HDR  = SW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRD    = 4'd1;  // search: read wait
    localparam logic [3:0] S_SCHK   = 4'd2;  // search: test entry
    localparam logic [3:0] S_SHRD   = 4'd3;  // split: read j-1
    localparam logic [3:0] S_SHWR   = 4'd4;  // split: write j
    localparam logic [3:0] S_SPLIT  = 4'd5;  // split: write k and k+1
    localparam logic [3:0] S_MRD    = 4'd6;  // merge: read entry k
    localparam logic [3:0] S_MCHK   = 4'd7;  // merge: compare pair
    localparam logic [3:0] S_RMRD   = 4'd8;  // remove: read j+1
    localparam logic [3:0] S_RMWR   = 4'd9;  // remove: write j
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_MLD    = 4'd11; // merge: latch entry k

    logic [3:0]    r_state, n_state;
    logic [31:0]   r_base;
    logic [16:0]   r_bytes;
    logic          r_ready;
    logic [CW-1:0] r_count, n_count;
    logic          r_mode;
    logic [SW-1:0] r_need;
    logic [31:0]   r_hdr;
    logic          r_zero;
    logic [CW-1:0] r_k, n_k;     // scan index
    logic [CW-1:0] r_j, n_j;     // shift index
    ffha_pkg::t_entry r_cur, n_cur;   // held entry (k)
    logic          r_ok, n_ok;
    logic [31:0]   r_addr, n_addr;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    ffha_pkg::t_entry     wdata, rdata;

    ffha_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;

    logic [SW-1:0] span;
    logic [SW-1:0] rnd_in;
    assign span   = {r_bytes[16:2], 2'b00};
    assign rnd_in = (SW'(i_request_bytes) + SW'(3)) & ~SW'(3);

    // header address match for free, and fit tests
    logic hit, fits, can_split;
    assign hit       = rdata.occ && ((r_base + 32'(rdata.off)) == r_hdr);
    assign fits      = !rdata.occ && (rdata.size >= r_need);
    assign can_split = (rdata.size > r_need + HDR) && (r_count < MAXC);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_k     = r_k;
        n_j     = r_j;
        n_cur   = r_cur;
        n_ok    = r_ok;
        n_addr  = r_addr;
        we      = 1'b0;
        waddr   = r_k[AW-1:0];
        wdata   = r_cur;
        raddr   = r_k[AW-1:0];
        case (r_state)
            S_IDLE: begin
                n_k  = '0;
                n_ok = 1'b0;
                n_addr = '0;
                // unbuilt table: one free block over the whole region
                if (i_start && !r_ready && (span > HDR)) begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata.off  = '0;
                    wdata.size = span;
                    wdata.occ  = 1'b0;
                end
            end
            S_SRD: begin
                if (r_k >= r_count || (r_mode == ffha_pkg::MODE_ALLOC && r_zero)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                n_cur = rdata;
                if (r_mode == ffha_pkg::MODE_ALLOC) begin
                    if (fits) begin
                        n_ok   = 1'b1;
                        n_addr = r_base + 32'(rdata.off) + 32'(HDR);
                        if (can_split) begin
                            n_j     = r_count;
                            n_state = S_SHRD;
                        end else begin
                            we      = 1'b1;
                            wdata   = rdata;
                            wdata.occ = 1'b1;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_k     = r_k + 1'b1;
                        raddr   = AW'(r_k + 1'b1);
                        n_state = S_SRD;
                    end
                end else begin
                    if (hit) begin
                        n_ok    = 1'b1;
                        we      = 1'b1;
                        wdata   = rdata;
                        wdata.occ = 1'b0;
                        n_k     = '0;
                        n_state = S_MRD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        raddr   = AW'(r_k + 1'b1);
                        n_state = S_SRD;
                    end
                end
            end
            S_SHRD: begin
                // move entry j-1 up to j while j > k+1
                if (r_j > r_k + 1'b1) begin
                    raddr   = AW'(r_j - 1'b1);
                    n_state = S_SHWR;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_SHWR: begin
                we      = 1'b1;
                waddr   = AW'(r_j);
                wdata   = rdata;
                n_j     = r_j - 1'b1;
                n_state = S_SHRD;
            end
            S_SPLIT: begin
                // writes the tail at k+1 first, then the head at k
                if (r_j != '0) begin
                    we         = 1'b1;
                    waddr      = AW'(r_k + 1'b1);
                    wdata.off  = r_cur.off + r_need;
                    wdata.size = r_cur.size - r_need;
                    wdata.occ  = 1'b0;
                    n_j        = '0;
                end else begin
                    we         = 1'b1;
                    wdata.off  = r_cur.off;
                    wdata.size = r_need;
                    wdata.occ  = 1'b1;
                    n_count    = r_count + 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_MRD: begin
                // read of entry k issued here
                if (r_k + 1'b1 >= r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MLD;
                end
            end
            S_MLD: begin
                // latch entry k and read k+1
                n_cur   = rdata;
                raddr   = AW'(r_k + 1'b1);
                n_state = S_MCHK;
            end
            S_MCHK: begin
                // cur holds entry k, rdata entry k+1
                if (!r_cur.occ && !rdata.occ &&
                    (r_cur.off + r_cur.size == rdata.off)) begin
                    n_cur.size = r_cur.size + rdata.size;
                    we         = 1'b1;
                    wdata      = r_cur;
                    wdata.size = r_cur.size + rdata.size;
                    n_j        = r_k + 1'b1;
                    n_state    = S_RMRD;
                end else begin
                    n_cur   = rdata;
                    n_k     = r_k + 1'b1;
                    raddr   = AW'(r_k + 2'd2);
                    if (r_k + 2'd2 >= r_count) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RMRD: begin
                // shift entries above j down by one, then test k again
                if (r_j + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    raddr   = AW'(r_k + 1'b1);
                    n_state = (r_k + 2'd2 >= r_count) ? S_DONE : S_MCHK;
                end else begin
                    raddr   = AW'(r_j + 1'b1);
                    n_state = S_RMWR;
                end
            end
            S_RMWR: begin
                we      = 1'b1;
                waddr   = AW'(r_j);
                wdata   = rdata;
                n_j     = r_j + 1'b1;
                n_state = S_RMRD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= 32'h2000_0000;
            r_bytes <= 17'd4096;
            r_ready <= 1'b0;
            r_count <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_ok    <= 1'b0;
            r_addr  <= '0;
            o_done  <= 1'b0;
        end else begin
            r_cur   <= n_cur;
            r_k     <= n_k;
            r_j     <= n_j;
            r_ok    <= n_ok;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_state <= n_state;
            o_done  <= 1'b0;
            if (r_state == S_IDLE && i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == ffha_pkg::REG_HEAP_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_bytes <= i_cfg_data[16:0];
                end
                r_ready <= 1'b0;
            end
            if (r_state == S_IDLE && i_start) begin
                r_mode    <= i_mode;
                r_need    <= rnd_in + HDR;
                r_zero    <= (i_request_bytes == 16'd0);
                r_hdr     <= i_release_address - 32'(HEADER_BYTES);
                r_j       <= '0;
                r_state   <= S_SRD;
                if (!r_ready) begin
                    r_ready <= 1'b1;
                    r_count <= (span > HDR) ? CW'(1) : '0;
                end
            end
            if (r_state == S_DONE) begin
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_payload_address <= r_ok && (r_mode == ffha_pkg::MODE_ALLOC) ? r_addr : 32'd0;
            o_success         <= r_ok;
        end
    end

endmodule
